[hdl/ltg_pkg.sv]
`timescale 1ns / 1ps

package ltg_pkg;

   // Grid dimensions used as defaults for the top level parameters.
   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_COLS_DEF = 64;

   // Field widths fixed by the interface.
   localparam int SIZE_W  = 7;
   localparam int COORD_W = 6;
   localparam int MODE_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [SIZE_W-1:0] ROWS_RESET = 7'd10;
   localparam logic [SIZE_W-1:0] COLS_RESET = 7'd20;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'd1;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CELL,
      ST_GEN_UP,
      ST_GEN_CUR,
      ST_GEN_ROW,
      ST_FINISH
   } state_type;

   // Row address source for the grid read port.
   typedef enum logic [2:0] {
      RD_REQ,
      RD_LAST,
      RD_ZERO,
      RD_ONE,
      RD_AHEAD
   } rd_sel_type;

   typedef struct packed {
      logic       req_load;
      logic       res_init;
      logic       cell_upd;
      logic       up_load;
      logic       cur_load;
      logic       gen_row;
      logic       rsp_load;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              bad;
      logic              last_row;
      logic              rsp_free;
   } sts_type;

endpackage

[hdl/life_torus_generation_core.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  req_tdata: mode, row, col, cell_in
// rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: cell_out, coord_error
// csr      in         csr_valid/csr_ready    csr_index, csr_data (grid size)
//
// One request at a time. Cell write/read walks the decode, cell and finish states; the
// response register loads in the finish state and the next request is taken back in idle;
// a flagged coordinate or unused mode skips the cell state. Generation step: decode, up and
// current row loads, then the clamped row count, one row a cycle through the single grid read port.
// Reset is synchronous; the grid reads as all dead through per-row valid bits,
// so no clearing pass is needed. The result register lets the next request be
// taken while a response waits; a stalled response holds the finish state.
module life_torus_generation_core #(
   parameter int MAX_ROWS = ltg_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = ltg_pkg::MAX_COLS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,  // mode[1:0] row[7:2] col[13:8] cell_in[14]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // cell_out[0] coord_error[1]
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ltg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ltg_pkg::SIZE_W-1:0]    csr_data
);

   ltg_pkg::cmd_type cmd;
   ltg_pkg::sts_type sts;
   logic             rsp_cell_out;
   logic             rsp_coord_error;

   // Sequencer: decodes the request mode and walks the generation rows.
   ltg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Grid store, three-row window, neighbor count and response register.
   ltg_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_tdata[1:0]),
      .req_row         (req_tdata[7:2]),
      .req_col         (req_tdata[13:8]),
      .req_cell_in     (req_tdata[14]),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_cell_out    (rsp_cell_out),
      .rsp_coord_error (rsp_coord_error)
   );

   // Pack the response fields, pad to a whole byte.
   assign rsp_tdata = {6'b0, rsp_coord_error, rsp_cell_out};

`ifndef ASSERT_OFF
   // A new result never overwrites a response that is still waiting.
   a_rsp_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("response loaded while slot busy");

   // Once a request is taken, the block is busy in the next cycle.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted twice back to back");

   // The last generation row ends the row walk.
   a_walk_ends : assert property (@(posedge clock) disable iff (reset)
      (cmd.gen_row && sts.last_row) |=> !cmd.gen_row)
      else $error("row walk continued past last row");
`endif

endmodule

[hdl/ltg_ctrl.sv]
`timescale 1ns / 1ps

module ltg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ltg_pkg::sts_type  sts,
   output ltg_pkg::cmd_type  cmd
);

   ltg_pkg::state_type state_ff;
   ltg_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ltg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.rd_sel = ltg_pkg::RD_REQ;
      unique case (state_ff)
         ltg_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.req_load = req_tvalid;
            if (req_tvalid) begin
               state_in = ltg_pkg::ST_DECODE;
            end
         end
         ltg_pkg::ST_DECODE: begin
            cmd.res_init = 1'b1;
            if (sts.mode == ltg_pkg::MODE_STEP) begin
               cmd.rd_sel = ltg_pkg::RD_LAST;
               state_in   = ltg_pkg::ST_GEN_UP;
            end else if ((sts.mode == ltg_pkg::MODE_WRITE || sts.mode == ltg_pkg::MODE_READ)
                         && !sts.bad) begin
               state_in = ltg_pkg::ST_CELL;
            end else begin
               state_in = ltg_pkg::ST_FINISH;
            end
         end
         ltg_pkg::ST_CELL: begin
            cmd.cell_upd = 1'b1;
            state_in     = ltg_pkg::ST_FINISH;
         end
         ltg_pkg::ST_GEN_UP: begin
            cmd.up_load = 1'b1;
            cmd.rd_sel  = ltg_pkg::RD_ZERO;
            state_in    = ltg_pkg::ST_GEN_CUR;
         end
         ltg_pkg::ST_GEN_CUR: begin
            cmd.cur_load = 1'b1;
            cmd.rd_sel   = ltg_pkg::RD_ONE;
            state_in     = ltg_pkg::ST_GEN_ROW;
         end
         ltg_pkg::ST_GEN_ROW: begin
            cmd.gen_row = 1'b1;
            cmd.rd_sel  = ltg_pkg::RD_AHEAD;
            if (sts.last_row) begin
               state_in = ltg_pkg::ST_FINISH;
            end
         end
         ltg_pkg::ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ltg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ltg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/ltg_datapath.sv]
`timescale 1ns / 1ps

module ltg_datapath #(
   parameter int MAX_ROWS = ltg_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = ltg_pkg::MAX_COLS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ltg_pkg::cmd_type              cmd,
   output ltg_pkg::sts_type              sts,
   input  logic [ltg_pkg::MODE_W-1:0]    req_mode,
   input  logic [ltg_pkg::COORD_W-1:0]   req_row,
   input  logic [ltg_pkg::COORD_W-1:0]   req_col,
   input  logic                          req_cell_in,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ltg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ltg_pkg::SIZE_W-1:0]    csr_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic                          rsp_cell_out,
   output logic                          rsp_coord_error
);

   localparam int RA_W  = $clog2(MAX_ROWS);
   localparam int CA_W  = $clog2(MAX_COLS);
   localparam int RN_W  = $clog2(MAX_ROWS + 1);
   localparam int CN_W  = $clog2(MAX_COLS + 1);
   localparam int SZ_R  = (RN_W > ltg_pkg::SIZE_W) ? RN_W : ltg_pkg::SIZE_W;
   localparam int SZ_C  = (CN_W > ltg_pkg::SIZE_W) ? CN_W : ltg_pkg::SIZE_W;

   // Configuration
   logic [ltg_pkg::SIZE_W-1:0] rows_ff;
   logic [ltg_pkg::SIZE_W-1:0] cols_ff;

   // Request
   logic [ltg_pkg::MODE_W-1:0]  mode_ff;
   logic [ltg_pkg::COORD_W-1:0] row_ff;
   logic [ltg_pkg::COORD_W-1:0] col_ff;
   logic                        cell_in_ff;

   // Result and response slot
   logic res_cell_ff;
   logic res_err_ff;
   logic rsp_valid_ff;
   logic rsp_cell_ff;
   logic rsp_err_ff;

   // Grid store: one word per row, row valid bits stand in for the reset clear
   logic [MAX_COLS-1:0] mem [MAX_ROWS];
   logic [MAX_ROWS-1:0] row_valid_ff;
   logic [MAX_COLS-1:0] rd_data_ff;
   logic                rd_valid_ff;
   logic [MAX_COLS-1:0] rd_row;
   logic [RA_W-1:0]     rd_addr;
   logic                wr_en;
   logic [RA_W-1:0]     wr_addr;
   logic [MAX_COLS-1:0] wr_data;

   // Generation window
   logic [MAX_COLS-1:0] up_ff;
   logic [MAX_COLS-1:0] cur_ff;
   logic [MAX_COLS-1:0] first_ff;
   logic [RA_W-1:0]     r_ff;
   logic [MAX_COLS-1:0] dn_row;
   logic [MAX_COLS-1:0] new_row;
   logic [MAX_COLS-1:0] cell_row;

   logic [SZ_R-1:0] nr;
   logic [SZ_C-1:0] nc;
   logic [RA_W-1:0] nr_m1;
   logic [CA_W-1:0] nc_m1;
   logic [RA_W:0]   ahead;
   logic [RA_W-1:0] req_row_addr;
   logic [CA_W-1:0] req_col_addr;
   logic            bad;
   logic            cell_mode;

   function automatic logic [MAX_COLS-1:0] wrap_left(input logic [MAX_COLS-1:0] x,
                                                     input logic [CA_W-1:0] last);
      logic [MAX_COLS-1:0] y;
      y[0] = x[last];
      for (int c = 1; c < MAX_COLS; c++) begin
         y[c] = x[c-1];
      end
      return y;
   endfunction

   function automatic logic [MAX_COLS-1:0] wrap_right(input logic [MAX_COLS-1:0] x,
                                                      input logic [CA_W-1:0] last);
      logic [MAX_COLS-1:0] y;
      for (int c = 0; c < MAX_COLS - 1; c++) begin
         y[c] = (last == CA_W'(c)) ? x[0] : x[c+1];
      end
      y[MAX_COLS-1] = x[0];
      return y;
   endfunction

   // Clamp the sizes in use: zero acts as one, oversize acts as the maximum.
   always_comb begin
      if (rows_ff == '0) begin
         nr = SZ_R'(1);
      end else if (SZ_R'(rows_ff) > SZ_R'(MAX_ROWS)) begin
         nr = SZ_R'(MAX_ROWS);
      end else begin
         nr = SZ_R'(rows_ff);
      end
      if (cols_ff == '0) begin
         nc = SZ_C'(1);
      end else if (SZ_C'(cols_ff) > SZ_C'(MAX_COLS)) begin
         nc = SZ_C'(MAX_COLS);
      end else begin
         nc = SZ_C'(cols_ff);
      end
   end

   assign nr_m1        = RA_W'(nr - SZ_R'(1));
   assign nc_m1        = CA_W'(nc - SZ_C'(1));
   assign bad          = (SZ_R'(row_ff) >= nr) || (SZ_C'(col_ff) >= nc);
   assign req_row_addr = RA_W'(row_ff);
   assign req_col_addr = CA_W'(col_ff);
   assign cell_mode    = (mode_ff == ltg_pkg::MODE_WRITE) || (mode_ff == ltg_pkg::MODE_READ);
   assign ahead        = {1'b0, r_ff} + (RA_W + 1)'(2);

   assign sts.mode     = mode_ff;
   assign sts.bad      = bad;
   assign sts.last_row = (r_ff == nr_m1);
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   assign csr_ready       = 1'b1;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_cell_out    = rsp_cell_ff;
   assign rsp_coord_error = rsp_err_ff;

   always_comb begin
      case (cmd.rd_sel)
         ltg_pkg::RD_REQ:   rd_addr = req_row_addr;
         ltg_pkg::RD_LAST:  rd_addr = nr_m1;
         ltg_pkg::RD_ZERO:  rd_addr = '0;
         ltg_pkg::RD_ONE:   rd_addr = RA_W'(1);
         ltg_pkg::RD_AHEAD: rd_addr = (ahead < (RA_W + 1)'(MAX_ROWS)) ? RA_W'(ahead) : '0;
         default:           rd_addr = '0;
      endcase
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;
   assign dn_row = sts.last_row ? first_ff : rd_row;

   // One generation row: count wrapped neighbors per column, apply B3/S23.
   always_comb begin
      logic [MAX_COLS-1:0] ul, ur, cl, cr, dl, dr;
      logic [3:0]          n;
      ul = wrap_left(up_ff, nc_m1);
      ur = wrap_right(up_ff, nc_m1);
      cl = wrap_left(cur_ff, nc_m1);
      cr = wrap_right(cur_ff, nc_m1);
      dl = wrap_left(dn_row, nc_m1);
      dr = wrap_right(dn_row, nc_m1);
      for (int c = 0; c < MAX_COLS; c++) begin
         n = 4'(ul[c]) + 4'(up_ff[c]) + 4'(ur[c]) + 4'(cl[c]) + 4'(cr[c])
           + 4'(dl[c]) + 4'(dn_row[c]) + 4'(dr[c]);
         if (CA_W'(c) <= nc_m1) begin
            new_row[c] = cur_ff[c] ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
         end else begin
            new_row[c] = cur_ff[c];
         end
      end
   end

   always_comb begin
      cell_row               = rd_row;
      cell_row[req_col_addr] = cell_in_ff;
   end

   assign wr_en   = cmd.gen_row || (cmd.cell_upd && mode_ff == ltg_pkg::MODE_WRITE);
   assign wr_addr = cmd.gen_row ? r_ff : req_row_addr;
   assign wr_data = cmd.gen_row ? new_row : cell_row;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
      rd_valid_ff <= row_valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ltg_pkg::ROWS_RESET;
         cols_ff <= ltg_pkg::COLS_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == ltg_pkg::CSR_ROWS) begin
            rows_ff <= csr_data;
         end
         if (csr_index == ltg_pkg::CSR_COLS) begin
            cols_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         mode_ff    <= req_mode;
         row_ff     <= req_row;
         col_ff     <= req_col;
         cell_in_ff <= req_cell_in;
      end
      if (cmd.res_init) begin
         res_cell_ff <= 1'b0;
         res_err_ff  <= cell_mode && bad;
      end else if (cmd.cell_upd && mode_ff == ltg_pkg::MODE_READ) begin
         res_cell_ff <= rd_row[req_col_addr];
      end
      if (cmd.rsp_load) begin
         rsp_cell_ff <= res_cell_ff;
         rsp_err_ff  <= res_err_ff;
      end
      if (cmd.up_load) begin
         up_ff <= rd_row;
      end
      if (cmd.cur_load) begin
         cur_ff   <= rd_row;
         first_ff <= rd_row;
         r_ff     <= '0;
      end
      if (cmd.gen_row) begin
         up_ff  <= cur_ff;
         cur_ff <= dn_row;
         r_ff   <= r_ff + RA_W'(1);
      end
   end

endmodule
